// File: hw/rtl/csf_pkg.sv
// Shared types and constants for the clock sync follower core.
// No dependencies; imported by every module of the block.
`default_nettype none

package csf_pkg;

    // Fixed field widths
    localparam int TS_BITS    = 48;
    localparam int NOW_BITS   = 47;
    localparam int LEVEL_BITS = 8;
    localparam int PEER_BITS  = 8;
    localparam int ATO_BITS   = 16;
    localparam int LTO_BITS   = 20;
    localparam int CFG_BITS   = 20;

    // Sum of the offset equation: 2*t1 - t0 - t3 plus sign
    localparam int SUM_BITS = TS_BITS + 2;

    // Levels
    localparam logic [LEVEL_BITS-1:0] LEVEL_UNSYNC = 8'd255;
    localparam logic [LEVEL_BITS-1:0] LEVEL_LEADER = 8'd0;
    localparam logic [LEVEL_BITS-1:0] LEVEL_LIMIT  = 8'd254;

    // Timeout reset values
    localparam logic [ATO_BITS-1:0] ATO_RESET = 16'd5000;
    localparam logic [LTO_BITS-1:0] LTO_RESET = 20'd20000;

    // Configuration register indexes
    localparam logic CFG_ATTEMPT_TIMEOUT = 1'b0;
    localparam logic CFG_LOSS_TIMEOUT    = 1'b1;

    // Request codes
    localparam logic [2:0] REQ_SYNC_START = 3'd0;
    localparam logic [2:0] REQ_DELAY_RESP = 3'd1;
    localparam logic [2:0] REQ_LEADER     = 3'd2;
    localparam logic [2:0] REQ_TICK       = 3'd3;
    localparam logic [2:0] REQ_QUERY      = 3'd4;

    typedef enum logic [2:0] {
        ST_ACCEPTED  = 3'd0,
        ST_REJECTED  = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_ATTEMPT_TO = 3'd3,
        ST_SYNC_LOST = 3'd4
    } status_t;

    // One input transaction
    typedef struct packed {
        logic [2:0]                  req_type;
        logic [PEER_BITS-1:0]        peer_id;
        logic                        peer_known;
        logic [LEVEL_BITS-1:0]       msg_level;
        logic signed [TS_BITS-1:0]   msg_timestamp;
        logic [NOW_BITS-1:0]         now_ms;
    } item_t;

    // Result of the update stage, before the synced time is formed
    typedef struct packed {
        status_t                     status;
        logic                        send_delay_request;
        logic [LEVEL_BITS-1:0]       level;
        logic signed [TS_BITS-1:0]   clock_offset;
        logic [NOW_BITS-1:0]         now_ms;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/csf_update.sv
// Sync state and per-event decision logic of the clock sync follower.
// Depends on csf_pkg; holds the follower state and the update-stage result register.
`default_nettype none

module csf_update
    import csf_pkg::*;
#(
    parameter int PEER_COUNT = 256
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire item_t               item,
    input  wire logic [ATO_BITS-1:0] attempt_timeout,
    input  wire logic [LTO_BITS-1:0] loss_timeout,
    output result_t                  res
);

    // Follower state
    logic [LEVEL_BITS-1:0]     own_level_reg, own_level_next;
    logic signed [TS_BITS-1:0] offset_reg, offset_next;
    logic                      master_valid_reg, master_valid_next;
    logic [PEER_BITS-1:0]      master_peer_reg, master_peer_next;
    logic                      attempt_valid_reg, attempt_valid_next;
    logic [PEER_BITS-1:0]      attempt_peer_reg, attempt_peer_next;
    logic [LEVEL_BITS-1:0]     attempt_level_reg, attempt_level_next;
    logic [NOW_BITS-1:0]       t0_reg, t0_next;   // sender timestamp, known non-negative
    logic [NOW_BITS-1:0]       t1_reg, t1_next;   // arrival time, t2 equals it
    logic                      last_sync_valid_reg, last_sync_valid_next;
    logic [NOW_BITS-1:0]       last_sync_reg, last_sync_next;
    result_t                   res_reg, res_next;

    logic signed [TS_BITS-1:0]  loss_diff;
    logic signed [TS_BITS-1:0]  att_diff;
    logic                       lost;
    logic                       att_expired;
    logic                       from_master;
    logic                       peer_ok;
    logic signed [SUM_BITS-1:0] sum;
    logic signed [SUM_BITS-1:0] half;
    status_t                    ev;
    logic                       send;

    // Timeout differences; time running backwards gives a negative value
    assign loss_diff = $signed({1'b0, item.now_ms}) - $signed({1'b0, last_sync_reg});
    assign att_diff  = $signed({1'b0, item.now_ms}) - $signed({1'b0, t1_reg});
    assign peer_ok   = 32'(item.peer_id) < 32'(PEER_COUNT);

    // Offset = (2*t1 - t0 - t3) / 2, truncated toward zero
    assign sum  = $signed({2'b00, t1_reg, 1'b0}) - $signed({3'b000, t0_reg})
                - $signed({{2{item.msg_timestamp[TS_BITS-1]}}, item.msg_timestamp});
    assign half = (sum + $signed({{(SUM_BITS-1){1'b0}}, sum[SUM_BITS-1]})) >>> 1;

    // Event processing after the timeout checks
    always_comb
    begin
        own_level_next       = own_level_reg;
        offset_next          = offset_reg;
        master_valid_next    = master_valid_reg;
        master_peer_next     = master_peer_reg;
        attempt_valid_next   = attempt_valid_reg;
        attempt_peer_next    = attempt_peer_reg;
        attempt_level_next   = attempt_level_reg;
        t0_next              = t0_reg;
        t1_next              = t1_reg;
        last_sync_valid_next = last_sync_valid_reg;
        last_sync_next       = last_sync_reg;
        ev                   = ST_ACCEPTED;
        send                 = 1'b0;

        lost = (own_level_reg != LEVEL_UNSYNC) && master_valid_reg && last_sync_valid_reg
            && (loss_diff > $signed({{(TS_BITS-LTO_BITS){1'b0}}, loss_timeout}));
        att_expired = attempt_valid_reg
            && (att_diff > $signed({{(TS_BITS-ATO_BITS){1'b0}}, attempt_timeout}));

        if (lost)
        begin
            own_level_next       = LEVEL_UNSYNC;
            master_valid_next    = 1'b0;
            last_sync_valid_next = 1'b0;
            offset_next          = '0;
        end
        if (att_expired)
        begin
            attempt_valid_next = 1'b0;
        end

        from_master = master_valid_next && (item.peer_id == master_peer_reg);

        case (item.req_type)
            REQ_SYNC_START:
            begin
                if (item.msg_timestamp[TS_BITS-1] || !item.peer_known || !peer_ok
                    || (item.msg_level >= LEVEL_LIMIT))
                begin
                    ev = ST_REJECTED;
                end
                else if ((item.msg_level >= own_level_next) && from_master)
                begin
                    // Master fell to or below us: drop sync entirely
                    own_level_next       = LEVEL_UNSYNC;
                    master_valid_next    = 1'b0;
                    attempt_valid_next   = 1'b0;
                    offset_next          = '0;
                    last_sync_valid_next = 1'b0;
                    ev                   = ST_DROPPED;
                end
                else if (({1'b0, item.msg_level} + 9'd1 >= {1'b0, own_level_next})
                         && !from_master)
                begin
                    ev = ST_REJECTED;
                end
                else
                begin
                    attempt_valid_next = 1'b1;
                    attempt_peer_next  = item.peer_id;
                    attempt_level_next = item.msg_level;
                    t0_next            = item.msg_timestamp[NOW_BITS-1:0];
                    t1_next            = item.now_ms;
                    send               = 1'b1;
                end
            end
            REQ_DELAY_RESP:
            begin
                if (!attempt_valid_next || (item.peer_id != attempt_peer_reg)
                    || (item.msg_level != attempt_level_reg))
                begin
                    ev = ST_REJECTED;
                end
                else if (item.msg_timestamp[TS_BITS-1])
                begin
                    attempt_valid_next = 1'b0;
                    ev                 = ST_REJECTED;
                end
                else
                begin
                    offset_next          = half[TS_BITS-1:0];
                    master_valid_next    = 1'b1;
                    master_peer_next     = item.peer_id;
                    own_level_next       = item.msg_level + 8'd1;
                    attempt_valid_next   = 1'b0;
                    last_sync_valid_next = 1'b1;
                    last_sync_next       = item.now_ms;
                end
            end
            REQ_LEADER:
            begin
                if (((own_level_next == LEVEL_LEADER) && (item.msg_level != LEVEL_UNSYNC))
                    || ((own_level_next != LEVEL_LEADER) && (item.msg_level != LEVEL_LEADER)))
                begin
                    ev = ST_REJECTED;
                end
                else
                begin
                    own_level_next       = (own_level_next == LEVEL_LEADER) ?
                                           LEVEL_UNSYNC : LEVEL_LEADER;
                    master_valid_next    = 1'b0;
                    attempt_valid_next   = 1'b0;
                    offset_next          = '0;
                    last_sync_valid_next = 1'b0;
                end
            end
            REQ_TICK, REQ_QUERY:
            begin
                ev = ST_ACCEPTED;
            end
            default:
            begin
                ev = ST_REJECTED;
            end
        endcase

        res_next.status             = lost ? ST_SYNC_LOST :
                                      (att_expired ? ST_ATTEMPT_TO : ev);
        res_next.send_delay_request = send;
        res_next.level              = own_level_next;
        res_next.clock_offset       = offset_next;
        res_next.now_ms             = item.now_ms;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_level_reg       <= LEVEL_UNSYNC;
            offset_reg          <= '0;
            master_valid_reg    <= 1'b0;
            attempt_valid_reg   <= 1'b0;
            last_sync_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            own_level_reg       <= own_level_next;
            offset_reg          <= offset_next;
            master_valid_reg    <= master_valid_next;
            attempt_valid_reg   <= attempt_valid_next;
            last_sync_valid_reg <= last_sync_valid_next;
        end
    end

    // Payload state, only read under its valid flag
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            master_peer_reg   <= master_peer_next;
            attempt_peer_reg  <= attempt_peer_next;
            attempt_level_reg <= attempt_level_next;
            t0_reg            <= t0_next;
            t1_reg            <= t1_next;
            last_sync_reg     <= last_sync_next;
            res_reg           <= res_next;
        end
    end

    assign res = res_reg;

    // Unsynced means no master and no offset
    a_unsync_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (own_level_reg == LEVEL_UNSYNC) |-> (!master_valid_reg && (offset_reg == '0)))
        else $error("unsynced level with master or offset");

    // A master always comes with a last sync time
    a_master_sync: assert property (@(posedge clk) disable iff (!rst_n)
        master_valid_reg |-> last_sync_valid_reg)
        else $error("master without last sync");

    // A delay request only follows an accepted sync start; a timeout may still show
    a_send_ok: assert property (@(posedge clk) disable iff (!rst_n)
        $past(load) && res_reg.send_delay_request |->
            (res_reg.status != ST_REJECTED) && (res_reg.status != ST_DROPPED)
            && attempt_valid_reg)
        else $error("delay request without open attempt");

endmodule

`default_nettype wire

// File: hw/rtl/csf_output.sv
// Output stage: forms the synced time and holds the result transaction.
// Depends on csf_pkg.
`default_nettype none

module csf_output
    import csf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 load,
    input  wire result_t              res,
    output logic [2:0]                status,
    output logic                      send_delay_request,
    output logic [LEVEL_BITS-1:0]     level,
    output logic signed [TS_BITS-1:0] clock_offset,
    output logic signed [TS_BITS-1:0] synced_time
);

    logic [2:0]                status_reg;
    logic                      send_reg;
    logic [LEVEL_BITS-1:0]     level_reg;
    logic signed [TS_BITS-1:0] offset_reg;
    logic signed [TS_BITS-1:0] synced_reg, synced_next;

    // now minus offset, wrapped to the time width
    assign synced_next = $signed({1'b0, res.now_ms}) - res.clock_offset;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= res.status;
            send_reg   <= res.send_delay_request;
            level_reg  <= res.level;
            offset_reg <= res.clock_offset;
            synced_reg <= synced_next;
        end
    end

    assign status             = status_reg;
    assign send_delay_request = send_reg;
    assign level              = level_reg;
    assign clock_offset       = offset_reg;
    assign synced_time        = synced_reg;

endmodule

`default_nettype wire

// File: hw/rtl/clock_sync_follower_core.sv
// Clock sync follower core, top level: input register, config, stage control.
// Pipeline: input, update and output stage between input transaction and result valid.
// Throughput: one transaction per cycle; the state update closes in the update stage.
// A stalled output holds the pipeline; empty stages still take new transactions.
// Reset: asynchronous active low; level 255, no master, no attempt, timeouts 5000/20000.
// Depends on csf_pkg, csf_update, csf_output.
`default_nettype none

module clock_sync_follower_core
    import csf_pkg::*;
#(
    parameter int PEER_COUNT = 256
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // input channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [2:0]            req_type,
    input  wire logic [PEER_BITS-1:0]  peer_id,
    input  wire logic                  peer_known,
    input  wire logic [LEVEL_BITS-1:0] msg_level,
    input  wire logic signed [TS_BITS-1:0] msg_timestamp,
    input  wire logic [NOW_BITS-1:0]   now_ms,
    // output channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [2:0]                 status,
    output logic                       send_delay_request,
    output logic [LEVEL_BITS-1:0]      level,
    output logic signed [TS_BITS-1:0]  clock_offset,
    output logic signed [TS_BITS-1:0]  synced_time,
    // configuration
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_BITS-1:0]   cfg_data
);

    logic                s1_valid_reg;
    logic                s2_valid_reg;
    logic                out_valid_reg;
    item_t               s1_item_reg;
    logic                s1_move;
    logic                s2_move;
    logic                in_accept;
    logic [ATO_BITS-1:0] ato_reg;
    logic [LTO_BITS-1:0] lto_reg;
    result_t             s2_res;

    // Stage advance: a stage moves when the next one is empty or moving
    assign s2_move   = s2_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_move   = s1_valid_reg && (!s2_valid_reg || s2_move);
    assign in_stall  = s1_valid_reg && !s1_move;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept || s1_move)
            begin
                s1_valid_reg <= in_accept;
            end
            if (s1_move || s2_move)
            begin
                s2_valid_reg <= s1_move;
            end
            if (s2_move || (out_valid_reg && !out_stall))
            begin
                out_valid_reg <= s2_move;
            end
        end
    end

    // Input register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_item_reg.req_type      <= req_type;
            s1_item_reg.peer_id       <= peer_id;
            s1_item_reg.peer_known    <= peer_known;
            s1_item_reg.msg_level     <= msg_level;
            s1_item_reg.msg_timestamp <= msg_timestamp;
            s1_item_reg.now_ms        <= now_ms;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ato_reg <= ATO_RESET;
            lto_reg <= LTO_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ATTEMPT_TIMEOUT: ato_reg <= cfg_data[ATO_BITS-1:0];
                CFG_LOSS_TIMEOUT:    lto_reg <= cfg_data[LTO_BITS-1:0];
                default:             ato_reg <= ato_reg;
            endcase
        end
    end

    csf_update #(
        .PEER_COUNT (PEER_COUNT)
    ) u_update (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (s1_move),
        .item            (s1_item_reg),
        .attempt_timeout (ato_reg),
        .loss_timeout    (lto_reg),
        .res             (s2_res)
    );

    csf_output u_output (
        .clk                (clk),
        .load               (s2_move),
        .res                (s2_res),
        .status             (status),
        .send_delay_request (send_delay_request),
        .level              (level),
        .clock_offset       (clock_offset),
        .synced_time        (synced_time)
    );

    assign out_valid = out_valid_reg;

    // A transaction taken into the update stage shows up there next cycle
    a_s2_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> s2_valid_reg)
        else $error("update stage lost a transaction");

    // A held result keeps the whole pipeline from overwriting it
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !s2_move)
        else $error("output overwritten while stalled");

    // Input stall only when the input stage is occupied
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s2_valid_reg)
        else $error("input stalled with free stage");

endmodule

`default_nettype wire

// File: tb/clock_sync_follower_core_tb.sv
// Self-checking testbench for clock_sync_follower_core: directed table, then random events.
// Depends on csf_pkg and the core RTL; expected results: table rows or an in-bench model.

module clock_sync_follower_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import csf_pkg::*;

    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 100;
    localparam int CALM_ITEMS   = 30;
    localparam int LIMIT_CYCLES = 400000;

    // Expected result of one event
    typedef struct packed {
        status_t                   status;
        logic                      send;
        logic [LEVEL_BITS-1:0]     level;
        logic signed [TS_BITS-1:0] offset;
        logic signed [TS_BITS-1:0] synced;
    } follower_out_t;

    // One row of the directed table
    typedef struct {
        item_t         it;
        bit            typed;
        follower_out_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [2:0]                req_type = '0;
    logic [PEER_BITS-1:0]      peer_id = '0;
    logic                      peer_known = 1'b0;
    logic [LEVEL_BITS-1:0]     msg_level = '0;
    logic signed [TS_BITS-1:0] msg_timestamp = '0;
    logic [NOW_BITS-1:0]       now_ms = '0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [2:0]                status;
    logic                      send_delay_request;
    logic [LEVEL_BITS-1:0]     level;
    logic signed [TS_BITS-1:0] clock_offset;
    logic signed [TS_BITS-1:0] synced_time;
    logic                      cfg_we = 1'b0;
    logic                      cfg_index = 1'b0;
    logic [CFG_BITS-1:0]       cfg_data = '0;

    // Model state of the follower
    logic [ATO_BITS-1:0]       cfg_attempt_to = ATO_RESET;
    logic [LTO_BITS-1:0]       cfg_loss_to = LTO_RESET;
    logic [LEVEL_BITS-1:0]     sync_level = LEVEL_UNSYNC;
    logic signed [TS_BITS-1:0] sync_offset = '0;
    logic                      master_ok = 1'b0;
    logic [PEER_BITS-1:0]      master_id = '0;
    logic                      try_open = 1'b0;
    logic [PEER_BITS-1:0]      try_peer = '0;
    logic [LEVEL_BITS-1:0]     try_level = '0;
    logic signed [TS_BITS-1:0] try_t0 = '0;
    logic signed [TS_BITS-1:0] try_t1 = '0;
    logic signed [TS_BITS-1:0] try_t2 = '0;
    logic                      last_ok = 1'b0;
    logic signed [TS_BITS-1:0] last_ms = '0;

    follower_out_t expected_q[$];
    dir_row_t      dir_rows[$];

    logic [NOW_BITS-1:0] clk_ms = '0;
    int gap_pct = 0;
    int stall_pct = 0;
    int item_count = 0;
    int checked = 0;
    int errors = 0;
    int cycles = 0;

    int unsigned ato_set[PHASES]   = '{1, 65535, 40, 3000, 1, 65535};
    int unsigned lto_set[PHASES]   = '{1, 1048575, 200, 12000, 1048575, 1};
    int          gap_set[PHASES]   = '{0, 0, 22, 84, 0, 22};
    int          stall_set[PHASES] = '{0, 84, 22, 0, 84, 22};

    clock_sync_follower_core u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .req_type           (req_type),
        .peer_id            (peer_id),
        .peer_known         (peer_known),
        .msg_level          (msg_level),
        .msg_timestamp      (msg_timestamp),
        .now_ms             (now_ms),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .status             (status),
        .send_delay_request (send_delay_request),
        .level              (level),
        .clock_offset       (clock_offset),
        .synced_time        (synced_time),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                     expected_q.size());
            $display("FAIL clock_sync_follower_core");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        if (stall_pct != 0 && $urandom_range(99, 0) < stall_pct)
            out_stall <= 1'b1;
        else
            out_stall <= 1'b0;
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin : result_check
        follower_out_t e;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with no transaction pending: status %0d level %0d",
                       status, level);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                checked++;
                if (status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, status);
                    errors++;
                end
                if (send_delay_request !== e.send)
                begin
                    $error("send_delay_request: expected %0d, got %0d", e.send,
                           send_delay_request);
                    errors++;
                end
                if (level !== e.level)
                begin
                    $error("level: expected %0d, got %0d", e.level, level);
                    errors++;
                end
                if (clock_offset !== e.offset)
                begin
                    $error("clock_offset: expected %0d, got %0d", e.offset, clock_offset);
                    errors++;
                end
                if (synced_time !== e.synced)
                begin
                    $error("synced_time: expected %0d, got %0d", e.synced, synced_time);
                    errors++;
                end
            end
        end
    end

    // Drop the open sync attempt
    function automatic void abandon_try();
        try_open  = 1'b0;
        try_peer  = '0;
        try_level = '0;
        try_t0    = '0;
        try_t1    = '0;
        try_t2    = '0;
    endfunction

    // Forget master, attempt, offset and last resync
    function automatic void forget_master();
        master_id   = '0;
        master_ok   = 1'b0;
        abandon_try();
        sync_offset = '0;
        last_ok     = 1'b0;
        last_ms     = '0;
    endfunction

    // Apply one event to the model state and return the result it produces
    function automatic follower_out_t follow_event(input item_t it);
        follower_out_t r;
        status_t       pre;
        status_t       ev;
        logic          send;
        logic          from_master;
        longint        now_l;
        longint        sum;
        longint        half;
        longint        diff;
        pre   = ST_ACCEPTED;
        ev    = ST_ACCEPTED;
        send  = 1'b0;
        now_l = longint'(it.now_ms);

        // timeouts first; backwards time gives negative differences
        if (sync_level != LEVEL_UNSYNC && master_ok && last_ok &&
            now_l - longint'(last_ms) > longint'(cfg_loss_to))
        begin
            sync_level  = LEVEL_UNSYNC;
            master_ok   = 1'b0;
            master_id   = '0;
            last_ok     = 1'b0;
            last_ms     = '0;
            sync_offset = '0;
            pre         = ST_SYNC_LOST;
        end
        if (try_open && now_l - longint'(try_t1) > longint'(cfg_attempt_to))
        begin
            abandon_try();
            if (pre == ST_ACCEPTED)
                pre = ST_ATTEMPT_TO;
        end

        case (it.req_type)
            REQ_SYNC_START:
            begin
                // every 8-bit peer index is below the peer count of 256
                from_master = master_ok && it.peer_id == master_id;
                if (it.msg_timestamp[TS_BITS-1] || !it.peer_known ||
                    it.msg_level >= LEVEL_LIMIT)
                    ev = ST_REJECTED;
                else if (it.msg_level >= sync_level && from_master)
                begin
                    sync_level = LEVEL_UNSYNC;
                    forget_master();
                    ev = ST_DROPPED;
                end
                else if ({1'b0, it.msg_level} + 9'd1 >= {1'b0, sync_level} && !from_master)
                    ev = ST_REJECTED;
                else
                begin
                    try_open  = 1'b1;
                    try_peer  = it.peer_id;
                    try_level = it.msg_level;
                    try_t0    = it.msg_timestamp;
                    try_t1    = {1'b0, it.now_ms};
                    try_t2    = {1'b0, it.now_ms};
                    send      = 1'b1;
                end
            end
            REQ_DELAY_RESP:
            begin
                if (!try_open || it.peer_id != try_peer || it.msg_level != try_level)
                    ev = ST_REJECTED;
                else if (it.msg_timestamp[TS_BITS-1])
                begin
                    abandon_try();
                    ev = ST_REJECTED;
                end
                else
                begin
                    sum = longint'(try_t1) - longint'(try_t0) + longint'(try_t2)
                        - longint'(it.msg_timestamp);
                    half        = sum / 2;   // truncates toward zero
                    sync_offset = half[TS_BITS-1:0];
                    master_ok   = 1'b1;
                    master_id   = it.peer_id;
                    sync_level  = it.msg_level + 8'd1;
                    abandon_try();
                    last_ok     = 1'b1;
                    last_ms     = {1'b0, it.now_ms};
                end
            end
            REQ_LEADER:
            begin
                if (sync_level == LEVEL_LEADER)
                begin
                    if (it.msg_level != LEVEL_UNSYNC)
                        ev = ST_REJECTED;
                    else
                    begin
                        sync_level = LEVEL_UNSYNC;
                        forget_master();
                    end
                end
                else if (it.msg_level != LEVEL_LEADER)
                    ev = ST_REJECTED;
                else
                begin
                    sync_level = LEVEL_LEADER;
                    forget_master();
                end
            end
            REQ_TICK, REQ_QUERY: ;
            default: ev = ST_REJECTED;
        endcase

        r.status = (pre != ST_ACCEPTED) ? pre : ev;
        r.send   = send;
        r.level  = sync_level;
        r.offset = sync_offset;
        diff     = now_l - longint'(sync_offset);
        r.synced = diff[TS_BITS-1:0];
        return r;
    endfunction

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    // Move the local millisecond clock: mostly small steps, some past the timeouts,
    // a few backwards
    function automatic void advance_clock();
        int unsigned pick;
        longint      t;
        pick = $urandom_range(99, 0);
        t    = longint'(clk_ms);
        if (pick < 70)
            t = t + longint'($urandom_range(20, 0));
        else if (pick < 85)
            t = t + longint'($urandom_range(2 * cfg_attempt_to + 1, 0));
        else if (pick < 93)
            t = t + longint'(cfg_loss_to) + longint'($urandom_range(cfg_attempt_to, 0));
        else
            t = t - longint'($urandom_range(5000, 0));
        if (t < 0)
            t = 0;
        clk_ms = t[NOW_BITS-1:0];
    endfunction

    // Present one transaction, hold it until accepted, then record its expectation
    task automatic drive_item(input item_t it, input bit typed, input follower_out_t want);
        follower_out_t got;
        while (gap_pct != 0 && $urandom_range(99, 0) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= it.req_type;
        peer_id       <= it.peer_id;
        peer_known    <= it.peer_known;
        msg_level     <= it.msg_level;
        msg_timestamp <= it.msg_timestamp;
        now_ms        <= it.now_ms;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        got = follow_event(it);
        expected_q.push_back(typed ? want : got);
        item_count++;
    endtask

    task automatic send_event(input logic [2:0] rq, input logic [7:0] pid, input logic kn,
                              input logic [7:0] lv, input logic [47:0] ts,
                              input logic [46:0] nw);
        item_t it;
        it.req_type      = rq;
        it.peer_id       = pid;
        it.peer_known    = kn;
        it.msg_level     = lv;
        it.msg_timestamp = ts;
        it.now_ms        = nw;
        drive_item(it, 1'b0, '0);
    endtask

    task automatic add_row(input logic [2:0] rq, input logic [7:0] pid, input logic kn,
                           input logic [7:0] lv, input logic [47:0] ts,
                           input logic [46:0] nw, input bit typed, input status_t st,
                           input logic snd, input logic [7:0] lvl,
                           input logic [47:0] off, input logic [47:0] syn);
        dir_row_t row;
        row.it.req_type      = rq;
        row.it.peer_id       = pid;
        row.it.peer_known    = kn;
        row.it.msg_level     = lv;
        row.it.msg_timestamp = ts;
        row.it.now_ms        = nw;
        row.typed            = typed;
        row.want.status      = st;
        row.want.send        = snd;
        row.want.level       = lvl;
        row.want.offset      = off;
        row.want.synced      = syn;
        dir_rows.push_back(row);
    endtask

    // Stop sending and wait until every result is back and the pipeline is empty
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [CFG_BITS-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        if (idx == CFG_ATTEMPT_TIMEOUT)
            cfg_attempt_to = val[ATO_BITS-1:0];
        else
            cfg_loss_to = val[LTO_BITS-1:0];
    endtask

    initial
    begin
        int          n_directed;
        int          start;
        int          p;
        int          hi;
        int          lo;
        int unsigned pick;
        logic        use_master;
        logic [7:0]  pid;
        logic [7:0]  lv;
        logic [2:0]  rq;
        longint      t0;
        longint      t3;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: reset values, field extremes, rejects, timeouts, drop, leader
        add_row(REQ_QUERY, 8'd0, 1'b0, 8'd0, 48'd0, 47'd0,
                1, ST_ACCEPTED, 1'b0, 8'd255, 48'd0, 48'd0);
        add_row(REQ_QUERY, 8'd255, 1'b1, 8'd255, 48'h8000_0000_0000, 47'h7FFF_FFFF_FFFF,
                1, ST_ACCEPTED, 1'b0, 8'd255, 48'd0, 48'h7FFF_FFFF_FFFF);
        add_row(3'd7, 8'd1, 1'b1, 8'd1, 48'd1, 47'd100,
                1, ST_REJECTED, 1'b0, 8'd255, 48'd0, 48'd100);
        add_row(REQ_SYNC_START, 8'd3, 1'b0, 8'd3, 48'd50, 47'd100,
                1, ST_REJECTED, 1'b0, 8'd255, 48'd0, 48'd100);
        add_row(REQ_SYNC_START, 8'd3, 1'b1, 8'd3, 48'hFFFF_FFFF_FFFF, 47'd100,
                1, ST_REJECTED, 1'b0, 8'd255, 48'd0, 48'd100);
        add_row(REQ_SYNC_START, 8'd3, 1'b1, 8'd254, 48'd50, 47'd100,
                1, ST_REJECTED, 1'b0, 8'd255, 48'd0, 48'd100);
        add_row(REQ_SYNC_START, 8'd3, 1'b1, 8'd255, 48'd50, 47'd100,
                1, ST_REJECTED, 1'b0, 8'd255, 48'd0, 48'd100);
        add_row(REQ_DELAY_RESP, 8'd3, 1'b1, 8'd3, 48'd50, 47'd100,
                1, ST_REJECTED, 1'b0, 8'd255, 48'd0, 48'd100);
        add_row(REQ_LEADER, 8'd3, 1'b1, 8'd5, 48'd50, 47'd100,
                1, ST_REJECTED, 1'b0, 8'd255, 48'd0, 48'd100);
        // full exchange with peer 255 at level 0
        add_row(REQ_SYNC_START, 8'd255, 1'b1, 8'd0, 48'd1000, 47'd1100,
                1, ST_ACCEPTED, 1'b1, 8'd255, 48'd0, 48'd1100);
        add_row(REQ_DELAY_RESP, 8'd255, 1'b1, 8'd0, 48'd1050, 47'd1120,
                0, ST_ACCEPTED, 1'b0, 8'd0, 48'd0, 48'd0);
        // other peer at a level not below ours minus one
        add_row(REQ_SYNC_START, 8'd40, 1'b1, 8'd0, 48'd1200, 47'd1200,
                0, ST_ACCEPTED, 1'b0, 8'd0, 48'd0, 48'd0);
        // master announces a level not below ours: sync dropped
        add_row(REQ_SYNC_START, 8'd255, 1'b1, 8'd1, 48'd1300, 47'd1300,
                1, ST_DROPPED, 1'b0, 8'd255, 48'd0, 48'd1300);
        // attempt left open past the attempt timeout
        add_row(REQ_SYNC_START, 8'd7, 1'b1, 8'd3, 48'd0, 47'd2000,
                1, ST_ACCEPTED, 1'b1, 8'd255, 48'd0, 48'd2000);
        add_row(REQ_TICK, 8'd0, 1'b0, 8'd0, 48'd0, 47'd7001,
                1, ST_ATTEMPT_TO, 1'b0, 8'd255, 48'd0, 48'd7001);
        // mismatched level, then negative response timestamp abandons the attempt
        add_row(REQ_SYNC_START, 8'd7, 1'b1, 8'd3, 48'd8000, 47'd8000,
                1, ST_ACCEPTED, 1'b1, 8'd255, 48'd0, 48'd8000);
        add_row(REQ_DELAY_RESP, 8'd7, 1'b1, 8'd4, 48'd8000, 47'd8005,
                1, ST_REJECTED, 1'b0, 8'd255, 48'd0, 48'd8005);
        add_row(REQ_DELAY_RESP, 8'd7, 1'b1, 8'd3, 48'h8000_0000_0000, 47'd8010,
                1, ST_REJECTED, 1'b0, 8'd255, 48'd0, 48'd8010);
        add_row(REQ_DELAY_RESP, 8'd7, 1'b1, 8'd3, 48'd8000, 47'd8020,
                1, ST_REJECTED, 1'b0, 8'd255, 48'd0, 48'd8020);
        // largest timestamps: odd negative sum, wrapped synced time
        add_row(REQ_SYNC_START, 8'd9, 1'b1, 8'd2, 48'h7FFF_FFFF_FFFF, 47'd9000,
                1, ST_ACCEPTED, 1'b1, 8'd255, 48'd0, 48'd9000);
        add_row(REQ_DELAY_RESP, 8'd9, 1'b1, 8'd2, 48'h7FFF_FFFF_FFFE, 47'd9010,
                0, ST_ACCEPTED, 1'b0, 8'd0, 48'd0, 48'd0);
        // time going backwards never times out
        add_row(REQ_QUERY, 8'd0, 1'b0, 8'd0, 48'd0, 47'd50,
                0, ST_ACCEPTED, 1'b0, 8'd0, 48'd0, 48'd0);
        // silence from the master past the loss timeout
        add_row(REQ_TICK, 8'd0, 1'b0, 8'd0, 48'd0, 47'd29011,
                1, ST_SYNC_LOST, 1'b0, 8'd255, 48'd0, 48'd29011);
        // leader on, bad level while leader, leader off
        add_row(REQ_LEADER, 8'd1, 1'b1, 8'd0, 48'd0, 47'd29012,
                1, ST_ACCEPTED, 1'b0, 8'd0, 48'd0, 48'd29012);
        add_row(REQ_LEADER, 8'd1, 1'b1, 8'd7, 48'd0, 47'd29013,
                1, ST_REJECTED, 1'b0, 8'd0, 48'd0, 48'd29013);
        add_row(REQ_LEADER, 8'd1, 1'b1, 8'd255, 48'd0, 47'd29014,
                1, ST_ACCEPTED, 1'b0, 8'd255, 48'd0, 48'd29014);

        foreach (dir_rows[i])
            drive_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
        n_directed = item_count;

        // Random phases, one timeout setting and idle pattern each
        for (p = 0; p < PHASES; p++)
        begin
            drain();
            write_cfg(CFG_ATTEMPT_TIMEOUT, CFG_BITS'(ato_set[p]));
            write_cfg(CFG_LOSS_TIMEOUT, CFG_BITS'(lto_set[p]));
            cfg_we <= 1'b0;
            if (p % 2 == 0)
                clk_ms = 47'($urandom_range(100000, 0));
            else
                clk_ms = 47'(rand48() >> 3);
            start = item_count;
            while (item_count - start < PHASE_ITEMS)
            begin
                gap_pct   = (item_count - start < CALM_ITEMS) ? 0 : gap_set[p];
                stall_pct = (item_count - start < CALM_ITEMS) ? 0 : stall_set[p];
                pick = $urandom_range(99, 0);
                if (pick < 40)
                begin
                    // sync exchange with an eligible peer, mostly completed
                    use_master = master_ok && ($urandom_range(1, 0) == 1);
                    pid = use_master ? master_id : 8'($urandom);
                    if (use_master && sync_level != LEVEL_LEADER)
                        hi = int'(sync_level) - 1;
                    else
                        hi = int'(sync_level) - 2;
                    if (hi > 253)
                        hi = 253;
                    if (hi < 0 || $urandom_range(9, 0) == 0)
                        lv = 8'($urandom);
                    else
                        lv = 8'($urandom_range(hi, 0));
                    advance_clock();
                    t0 = longint'(clk_ms) + longint'($urandom_range(2000, 0)) - 1000;
                    if (t0 < 0)
                        t0 = 0;
                    send_event(REQ_SYNC_START, pid, ($urandom_range(19, 0) != 0), lv,
                               t0[47:0], clk_ms);
                    if ($urandom_range(4, 0) == 0)
                    begin
                        advance_clock();
                        send_event(($urandom_range(1, 0) == 1) ? REQ_TICK : REQ_QUERY,
                                   8'($urandom), 1'($urandom), 8'($urandom), rand48(),
                                   clk_ms);
                    end
                    advance_clock();
                    t3 = t0 + longint'($urandom_range(2000, 0)) - 1000;
                    if ($urandom_range(19, 0) == 0)
                        t3 = -1 - longint'($urandom_range(1000, 0));
                    else if (t3 < 0)
                        t3 = 0;
                    case ($urandom_range(19, 0))
                        0: pid = pid + 8'd1;
                        1: lv = lv + 8'd1;
                        default: ;
                    endcase
                    send_event(REQ_DELAY_RESP, pid, 1'b1, lv, t3[47:0], clk_ms);
                end
                else if (pick < 50)
                begin
                    // leader toggles with good and bad levels
                    case ($urandom_range(3, 0))
                        0: lv = LEVEL_LEADER;
                        1: lv = LEVEL_UNSYNC;
                        2: lv = 8'($urandom);
                        default: lv = (sync_level == LEVEL_LEADER) ? LEVEL_UNSYNC
                                                                   : LEVEL_LEADER;
                    endcase
                    advance_clock();
                    send_event(REQ_LEADER, 8'($urandom), 1'($urandom), lv, rand48(), clk_ms);
                end
                else if (pick < 65)
                begin
                    // tick or query, exercising the timeouts
                    advance_clock();
                    send_event(($urandom_range(1, 0) == 1) ? REQ_TICK : REQ_QUERY,
                               8'($urandom), 1'($urandom), 8'($urandom), rand48(), clk_ms);
                end
                else if (pick < 75)
                begin
                    // sync start at a level from ours minus one to 253; mostly drops sync or not eligible
                    lo = int'(sync_level) - 1;
                    if (lo < 0)
                        lo = 0;
                    if (lo > 253)
                        lo = 253;
                    pid = master_ok ? master_id : 8'($urandom);
                    lv  = 8'($urandom_range(253, lo));
                    advance_clock();
                    send_event(REQ_SYNC_START, pid, 1'b1, lv,
                               {1'b0, clk_ms}, clk_ms);
                end
                else
                begin
                    // noise: any request type, any field value
                    rq = 3'($urandom);
                    if ($urandom_range(1, 0) == 1)
                        send_event(rq, 8'($urandom), 1'($urandom), 8'($urandom), rand48(),
                                   clk_ms);
                    else
                        send_event(rq, 8'($urandom), 1'($urandom), 8'($urandom), rand48(),
                                   47'(rand48()));
                end
            end
        end

        drain();
        repeat (10) @(posedge clk);

        $display("Ran %0d directed and %0d random transactions over %0d timeout settings",
                 n_directed, item_count - n_directed, PHASES);
        $display("with mixed sender gaps and receiver stalls; %0d results compared.", checked);
        if (errors == 0)
            $display("PASS clock_sync_follower_core");
        else
            $display("FAIL clock_sync_follower_core");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/csf_pkg.sv
hw/rtl/csf_update.sv
hw/rtl/csf_output.sv
hw/rtl/clock_sync_follower_core.sv
tb/clock_sync_follower_core_tb.sv
